@@ rtl/dpod_pkg.sv @@
// shared types, constants and calendar helper functions for the date period overlap block
package dpod_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int NUM_DATES = 4;

    // shifted year (year + 399) and day numbers
    localparam int SHY_W  = 15;
    localparam int Q100_W = 8;
    localparam int DNUM_W = 23;
    localparam int COUNT_W = 22;

    localparam logic [SHY_W-1:0]   YEAR_SHIFT  = 15'd399;
    localparam logic [12:0]        DIV100_MUL  = 13'd5243;
    localparam int                 DIV100_SHR  = 19;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 22'd4194303;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] num;
    } day_info_t;

    // floor(x / 100) by reciprocal multiply, exact for x below 25600
    function automatic logic [Q100_W-1:0] div100(input logic [SHY_W-1:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(DIV100_MUL);
        return prod[DIV100_SHR+Q100_W-1:DIV100_SHR];
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    return 9'd0;
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        case (m)
            4'd2:                      return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        return 5'd31;
            default:                   return 5'd0;
        endcase
    endfunction

endpackage

@@ rtl/dpod_day_conv.sv @@
// one date to serial day number plus calendar validity check
module dpod_day_conv
    import dpod_pkg::*;
(
    input  date_t                date_i,
    input  logic [Q100_W-1:0]    year_q_i,   // year / 100
    input  logic [Q100_W-1:0]    shy_q_i,    // (year + 399) / 100
    output day_info_t            info_o
);

    logic [SHY_W-1:0]  shy;
    logic [SHY_W-1:0]  cent_base;
    logic              cent_year;
    logic              leap;
    logic              month_ok;
    logic [DAY_W-1:0]  len;
    logic              leap_add;

    assign shy       = SHY_W'(date_i.year) + YEAR_SHIFT;
    assign cent_base = SHY_W'(year_q_i) * SHY_W'(100);
    assign cent_year = (SHY_W'(date_i.year) == cent_base);
    // divisible by 400 when divisible by 100 and the quotient by 4
    assign leap = (date_i.year[1:0] == 2'b00) && (!cent_year || (year_q_i[1:0] == 2'b00));

    assign month_ok = (date_i.month >= MONTH_JAN) && (date_i.month <= MONTH_DEC);
    assign len      = month_days(date_i.month, leap);
    assign leap_add = leap && (date_i.month > MONTH_FEB);

    assign info_o.ok  = month_ok && (date_i.day != '0) && (date_i.day <= len);
    assign info_o.num = DNUM_W'(shy) * DNUM_W'(365)
                      + DNUM_W'(shy[SHY_W-1:2])
                      - DNUM_W'(shy_q_i)
                      + DNUM_W'(shy_q_i[Q100_W-1:2])
                      + DNUM_W'(days_before(date_i.month))
                      + DNUM_W'(leap_add)
                      + DNUM_W'(date_i.day);

endmodule

@@ rtl/date_period_overlap_days_unit.sv @@
// top level: overlap in days of two inclusive gregorian date periods
//
// usage
//   s_ channel takes one request per handshake: four dates, the start and end
//   of a first period then the start and end of a second period
//   m_ channel returns one result per request, in order: the inclusive count
//   of days both periods share on m_tdata and a bad-date flag on m_tuser
//   any date with a month outside 1..12, a zero day or a day beyond its month
//   gives count zero with the flag set; disjoint periods give count zero
// timing
//   five register stages (input, quotients, day numbers, start/end, result),
//   which each request passes through in order before its result shows on m_
//   one request per cycle sustained while m_tready is high; each stage is a
//   short path, the widest being the year*365 day number sum
// reset and stalls
//   aresetn low (synchronous) empties all stages; no result is pending after it
//   while m_tready is low a finished result holds on m_ and the stages behind
//   it keep filling, so up to four more requests are taken before s_tready drops
module date_period_overlap_days_unit
    import dpod_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // first_start_year, first_start_month, first_start_day, first_end_year,
    // first_end_month, first_end_day, second_start_year, second_start_month,
    // second_start_day, second_end_year, second_end_month, second_end_day,
    // zero fill [95:92]
    input  logic [95:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // overlap_days [21:0], zero fill [23:22]
    output logic [23:0] m_tdata,
    // date_error [0]
    output logic        m_tuser
);

    localparam int NUM_ST = 5;

    // per stage valid bits and the ready chain running back from the sink
    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] vld_next;
    logic [NUM_ST:0]   rdy;
    logic [NUM_ST-1:0] in_vld;
    logic [NUM_ST-1:0] ld;

    always_comb begin
        rdy[NUM_ST] = m_tready;
        for (int k = NUM_ST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        in_vld[0] = s_tvalid;
        for (int k = 1; k < NUM_ST; k++) begin
            in_vld[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NUM_ST; k++) begin
            ld[k]       = rdy[k] && in_vld[k];
            vld_next[k] = rdy[k] ? in_vld[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 0: request register
    date_t s0_date_reg [NUM_DATES];

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            for (int i = 0; i < NUM_DATES; i++) begin
                s0_date_reg[i] <= s_tdata[i*DATE_W +: DATE_W];
            end
        end
    end

    // stage 1: century quotients of year and shifted year
    date_t             s1_date_reg [NUM_DATES];
    logic [Q100_W-1:0] s1_yq_reg   [NUM_DATES];
    logic [Q100_W-1:0] s1_sq_reg   [NUM_DATES];

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            for (int i = 0; i < NUM_DATES; i++) begin
                s1_date_reg[i] <= s0_date_reg[i];
                s1_yq_reg[i]   <= div100(SHY_W'(s0_date_reg[i].year));
                s1_sq_reg[i]   <= div100(SHY_W'(s0_date_reg[i].year) + YEAR_SHIFT);
            end
        end
    end

    // stage 2: serial day numbers and validity
    day_info_t conv_info [NUM_DATES];
    logic [DNUM_W-1:0] s2_num_reg [NUM_DATES];
    logic              s2_err_reg;

    for (genvar g = 0; g < NUM_DATES; g++) begin : g_conv
        dpod_day_conv u_conv (
            .date_i   (s1_date_reg[g]),
            .year_q_i (s1_yq_reg[g]),
            .shy_q_i  (s1_sq_reg[g]),
            .info_o   (conv_info[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            for (int i = 0; i < NUM_DATES; i++) begin
                s2_num_reg[i] <= conv_info[i].num;
            end
            s2_err_reg <= !(conv_info[0].ok && conv_info[1].ok &&
                            conv_info[2].ok && conv_info[3].ok);
        end
    end

    // stage 3: later start and earlier end
    logic [DNUM_W-1:0] s3_start_reg;
    logic [DNUM_W-1:0] s3_end_reg;
    logic              s3_err_reg;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            s3_start_reg <= (s2_num_reg[0] > s2_num_reg[2]) ? s2_num_reg[0] : s2_num_reg[2];
            s3_end_reg   <= (s2_num_reg[1] < s2_num_reg[3]) ? s2_num_reg[1] : s2_num_reg[3];
            s3_err_reg   <= s2_err_reg;
        end
    end

    // stage 4: inclusive count, saturated
    logic [DNUM_W-1:0]  span;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] days_reg;
    logic               err_reg;

    assign span = s3_end_reg - s3_start_reg;

    always_comb begin
        if (s3_err_reg || (s3_end_reg < s3_start_reg)) begin
            count_next = '0;
        end else if (span >= DNUM_W'(COUNT_MAX)) begin
            count_next = COUNT_MAX;
        end else begin
            count_next = span[COUNT_W-1:0] + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            days_reg <= count_next;
            err_reg  <= s3_err_reg;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_ST-1];
    assign m_tdata  = {2'b00, days_reg};
    assign m_tuser  = err_reg;

    // a bad date never reports a nonzero count
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[COUNT_W-1:0] == '0))
        else $error("bad-date result carries a nonzero count");

    // meeting periods with good dates give a nonzero count
    a_meet_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ld[4] && !s3_err_reg && (s3_end_reg >= s3_start_reg)
        |=> (m_tdata[COUNT_W-1:0] != '0))
        else $error("overlapping periods gave a zero count");

    // a stage blocked from below keeps its item
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && !rdy[4] |=> vld_reg[3])
        else $error("pipeline stage dropped an item while stalled");

endmodule
